// ===== sv/kctt_pkg.sv =====
// kctt_pkg: shared types and constants of the keyed countdown timer table
// request and result structs, request kinds, table entry layout
// no dependencies
package kctt_pkg;

  localparam int KEY_BITS       = 16;
  localparam int TIME_BITS      = 16;
  localparam int OUT_CNT_BITS   = 6;
  localparam int TABLE_SIZE_DEF = 32;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_DEL   = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [KEY_BITS-1:0]   key;
    logic [TIME_BITS-1:0]  wait_ticks;
    logic                  repeat_req;
  } in_t;

  typedef struct packed {
    logic                    status;
    logic                    fired;
    logic [KEY_BITS-1:0]     fired_key;
    logic                    last;
    logic [OUT_CNT_BITS-1:0] active_count;
  } out_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]  key;
    logic [TIME_BITS-1:0] wait_ticks;
    logic [TIME_BITS-1:0] reload;
  } entry_t;

endpackage

// ===== sv/kctt_ram.sv =====
// kctt_ram: generic single write port, single read port ram
// registered read data, no reset on the array
// no dependencies
module kctt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/keyed_countdown_timer_table.sv =====
// keyed_countdown_timer_table: table of keyed countdown timers with auto-reload
// uses kctt_pkg (types, kinds) and kctt_ram (entry table, fired key buffer)
//
//   channel  ports                     handshake
//   -------  ------------------------  ----------------------------------------
//   request  start, busy, in_req       taken at a rising edge with start && !busy
//   result   out_valid, out_rsp        one-cycle strobe, receiver always takes it
//
// sequencing: a shared read/modify/write sequencer walks the entry ram, one entry
//   per pass. tick: each entry is read, then checked; a one-shot that expires also
//   reads the last entry and copies it in, then each fired key is read and sent.
//   add scans up from slot zero, delete scans down from the last slot, clear
//   answers straight from idle, as does any request on an empty table.
// reset: synchronous, clears the entry count and the sequencer; entry ram
//   slots at or above the count are never read, so they need no clearing.
// stalls: busy is high while a request is in work; results cannot be stalled.
module keyed_countdown_timer_table
  #(
    parameter int TABLE_SIZE = kctt_pkg::TABLE_SIZE_DEF
  ) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  kctt_pkg::in_t  in_req,
    output logic           out_valid,
    output kctt_pkg::out_t out_rsp
  );

  import kctt_pkg::*;

  // index and count widths follow the table depth
  localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int CNT_W = $clog2(TABLE_SIZE + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CHK,
    ST_MV,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_t;

  // sequencer state and registered outputs
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  nfire_r, nfire_nxt;
  logic [IDX_W-1:0]  emit_r, emit_nxt;
  in_t               req_r, req_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              rsp_r, rsp_nxt;

  // entry ram port
  logic              ent_we;
  logic [IDX_W-1:0]  ent_waddr;
  entry_t            ent_wdata;
  logic [IDX_W-1:0]  ent_raddr;
  entry_t            ent_rdata;

  // fired key buffer port
  logic                fk_we;
  logic [IDX_W-1:0]    fk_waddr;
  logic [KEY_BITS-1:0] fk_wdata;
  logic [IDX_W-1:0]    fk_raddr;
  logic [KEY_BITS-1:0] fk_rdata;

  // sequencer helpers
  logic                 tick_adv;
  logic                 fin;
  logic                 fin_status;
  logic [CNT_W-1:0]     count_less1;
  logic [IDX_W-1:0]     last_idx;
  logic [TIME_BITS-1:0] wait_dec;
  logic                 emit_last;

  kctt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_SIZE)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  // keys of expired timers, in scan order, replayed after the scan
  kctt_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (TABLE_SIZE)
  ) u_fired_ram (
    .clk   (clk),
    .we    (fk_we),
    .waddr (fk_waddr),
    .wdata (fk_wdata),
    .raddr (fk_raddr),
    .rdata (fk_rdata)
  );

  function automatic entry_t mk_entry(in_t r);
    entry_t e;
    e.key        = r.key;
    e.wait_ticks = r.wait_ticks;
    e.reload     = r.repeat_req ? r.wait_ticks : '0;
    return e;
  endfunction

  function automatic out_t mk_rsp(logic st, logic fi, logic [KEY_BITS-1:0] k,
                                  logic la, logic [CNT_W-1:0] c);
    out_t o;
    o.status       = st;
    o.fired        = fi;
    o.fired_key    = k;
    o.last         = la;
    o.active_count = OUT_CNT_BITS'(c);
    return o;
  endfunction

  // index of the highest occupied slot
  assign count_less1 = count_r - CNT_W'(1);
  assign last_idx    = count_less1[IDX_W-1:0];
  // saturating decrement of the wait read back
  assign wait_dec  = (ent_rdata.wait_ticks == '0) ? '0
                     : ent_rdata.wait_ticks - TIME_BITS'(1);
  assign emit_last = ((CNT_W'(emit_r) + CNT_W'(1)) == nfire_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    nfire_nxt     = nfire_r;
    emit_nxt      = emit_r;
    req_nxt       = req_r;
    out_valid_nxt = 1'b0;
    rsp_nxt       = rsp_r;

    ent_we    = 1'b0;
    ent_waddr = idx_r;
    ent_wdata = ent_rdata;
    ent_raddr = idx_r;
    fk_we     = 1'b0;
    fk_waddr  = nfire_r[IDX_W-1:0];
    fk_wdata  = ent_rdata.key;
    fk_raddr  = emit_r;

    tick_adv   = 1'b0;
    fin        = 1'b0;
    fin_status = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt   = in_req;
          nfire_nxt = '0;
          case (in_req.kind)
            KIND_TICK: begin
              if (count_r == '0) begin
                fin = 1'b1;
              end else begin
                idx_nxt   = last_idx;
                state_nxt = ST_RD;
              end
            end
            KIND_ADD: begin
              // empty table: append straight into slot zero
              if (count_r == '0) begin
                ent_we    = 1'b1;
                ent_waddr = '0;
                ent_wdata = mk_entry(in_req);
                count_nxt = CNT_W'(1);
                fin       = 1'b1;
              end else begin
                idx_nxt   = '0;
                state_nxt = ST_RD;
              end
            end
            KIND_DEL: begin
              if (count_r == '0) begin
                fin = 1'b1;
              end else begin
                idx_nxt   = last_idx;
                state_nxt = ST_RD;
              end
            end
            default: begin
              count_nxt = '0;
              fin       = 1'b1;
            end
          endcase
        end
      end

      ST_RD: begin
        state_nxt = ST_CHK;
      end

      ST_CHK: begin
        case (req_r.kind)
          KIND_TICK: begin
            if (wait_dec != '0) begin
              ent_we               = 1'b1;
              ent_wdata.wait_ticks = wait_dec;
              tick_adv             = 1'b1;
            end else begin
              fk_we     = 1'b1;
              nfire_nxt = nfire_r + CNT_W'(1);
              if (ent_rdata.reload != '0) begin
                // periodic: reload the wait
                ent_we               = 1'b1;
                ent_wdata.wait_ticks = ent_rdata.reload;
                tick_adv             = 1'b1;
              end else begin
                // one-shot: fetch the last entry to fill this slot
                ent_raddr = last_idx;
                state_nxt = ST_MV;
              end
            end
          end
          KIND_ADD: begin
            if (ent_rdata.key == req_r.key) begin
              ent_we    = 1'b1;
              ent_wdata = mk_entry(req_r);
              fin       = 1'b1;
            end else if (idx_r == last_idx) begin
              if (count_r < CNT_W'(TABLE_SIZE)) begin
                ent_we    = 1'b1;
                ent_waddr = count_r[IDX_W-1:0];
                ent_wdata = mk_entry(req_r);
                count_nxt = count_r + CNT_W'(1);
              end else begin
                fin_status = 1'b1;
              end
              fin = 1'b1;
            end else begin
              idx_nxt   = idx_r + IDX_W'(1);
              state_nxt = ST_RD;
            end
          end
          KIND_DEL: begin
            if (ent_rdata.key == req_r.key) begin
              ent_raddr = last_idx;
              state_nxt = ST_MV;
            end else if (idx_r == '0) begin
              fin = 1'b1;
            end else begin
              idx_nxt   = idx_r - IDX_W'(1);
              state_nxt = ST_RD;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end

      ST_MV: begin
        // copy the last entry into the freed slot and shrink the table
        ent_we    = 1'b1;
        ent_wdata = ent_rdata;
        count_nxt = count_r - CNT_W'(1);
        if (req_r.kind == KIND_TICK) begin
          tick_adv = 1'b1;
        end else begin
          fin = 1'b1;
        end
      end

      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_OUT;
      end

      ST_EMIT_OUT: begin
        out_valid_nxt = 1'b1;
        rsp_nxt       = mk_rsp(1'b0, 1'b1, fk_rdata, emit_last, count_r);
        if (emit_last) begin
          state_nxt = ST_IDLE;
        end else begin
          emit_nxt  = emit_r + IDX_W'(1);
          state_nxt = ST_EMIT_RD;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // tick scan steps downward; at slot zero either replay fired keys or report none
    if (tick_adv) begin
      if (idx_r == '0) begin
        if (nfire_nxt == '0) begin
          fin = 1'b1;
        end else begin
          emit_nxt  = '0;
          state_nxt = ST_EMIT_RD;
        end
      end else begin
        idx_nxt   = idx_r - IDX_W'(1);
        state_nxt = ST_RD;
      end
    end

    // single result for add, delete, clear and a quiet tick
    if (fin) begin
      out_valid_nxt = 1'b1;
      rsp_nxt       = mk_rsp(fin_status, 1'b0, '0, 1'b1, count_nxt);
      state_nxt     = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r   <= idx_nxt;
    nfire_r <= nfire_nxt;
    emit_r  <= emit_nxt;
    req_r   <= req_nxt;
    rsp_r   <= rsp_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

  // table never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_SIZE))
    else $error("entry count above table size");

  // every request finishes with a result strobe as the sequencer goes idle
  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> (out_valid && out_rsp.last))
    else $error("sequencer went idle without a final result");

  // a result only follows a taken request or work in progress
  a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(rst_n)) |-> $past(busy || start))
    else $error("result strobe without a request");

  // fired results never report a refused add, nor appear in the scan read state
  a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.fired) |-> (!out_rsp.status && state_r != ST_RD))
    else $error("fired result with bad status or during scan");

endmodule
